// ===== rtl/lmt_pkg.sv =====
// Shared types and constants for the 3x3 local-mean threshold block.
// No dependencies; imported by the top level, the RAM users and the checker.
package lmt_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;

    localparam int PIX_W  = 8;
    localparam int FW_W   = 10;
    localparam int FH_W   = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int OROW_W = ROW_W + 1;
    localparam int SUM_W  = PIX_W + 4;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int FRAME_WIDTH_RESET  = 320;
    localparam int FRAME_HEIGHT_RESET = 240;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } lmt_cmd_t;

    // Control carried with a word from the accept edge to the data stage.
    typedef struct packed {
        logic             wr;
        logic             have;
        logic             drain;
        logic             sel_above;
        logic             border;
        logic             frame_end;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] px;
    } lmt_stage_t;

endpackage

// ===== rtl/lmt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for both line buffers.
module lmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/local_mean_threshold_3x3.sv =====
// Top level of the streaming 3x3 local-mean threshold.
// Depends on lmt_pkg and lmt_ram (two line buffers).
//
// Usage:
//   Input words arrive on s_valid/s_ready: s_cmd selects a pixel word or a
//   drain tick, s_pixel_in carries the pixel and s_frame_start marks the
//   first pixel of a frame. Result words leave on m_valid/m_ready with
//   m_pixel_out and m_frame_end, the latter set on the frame's last result.
//   Results trail the pixel stream by one line plus one pixel; after the
//   last pixel of a frame, one drain tick per pending result flushes the
//   bottom row.
//   Each accepted word is read from the line buffers at the accept edge,
//   combined with the window in the following cycle and, if it yields a
//   result, enters the output register that drives m_valid when the data
//   stage advances. One word is taken per cycle unless the data stage stalls;
//   the line buffer read-modify-write is the loop that sets this, with
//   forwarding when a read meets the write of the word just ahead of it.
//   When the receiver holds m_ready low, the output register keeps its word
//   and a result word in the data stage stalls behind it, so s_ready drops.
//   Reset (aresetn low at a clock edge) empties the pipeline, clears the
//   frame position and window, and sets width 320 and height 240. The line
//   buffers are not cleared. A register write over the APB port restarts
//   the frame position.
module local_mean_threshold_3x3
    import lmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [PIX_W-1:0]  s_pixel_in,
    input  logic              s_frame_start,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_pixel_out,
    output logic              m_frame_end,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration.
    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic              cfg_wr;
    logic              reg_idx;

    // Frame position.
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic              done_reg, done_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    // Accept-edge decode.
    logic              acc;
    logic              restart;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic              done_c;
    logic [OROW_W-1:0] orow_c;
    logic [COL_W-1:0]  ocol_c;
    logic              pix_ok;
    logic              pix_have;
    logic              drain_ok;
    logic              res;
    logic              fend;
    logic [COL_W-1:0]  rd_addr;
    logic              rd_en;

    // Data stage.
    logic              p1_valid_reg, p1_valid_next;
    lmt_stage_t        p1_reg;
    logic              p1_adv;
    logic              fwd_reg;
    logic [PIX_W-1:0]  fwd_two_reg;
    logic [PIX_W-1:0]  fwd_above_reg;
    logic [PIX_W-1:0]  two_q;
    logic [PIX_W-1:0]  above_q;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;
    logic [PIX_W-1:0]  win_reg [9];
    logic [PIX_W-1:0]  win_new [9];
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  nine_c;
    logic [PIX_W-1:0]  val;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  pixel_out_reg;
    logic              frame_end_reg;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1];

    always_comb begin
        if (reg_idx == REG_FRAME_HEIGHT) begin
            prdata = DATA_W'(frame_height_reg);
        end else begin
            prdata = DATA_W'(frame_width_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(FRAME_WIDTH_RESET);
            frame_height_reg <= FH_W'(FRAME_HEIGHT_RESET);
        end else if (cfg_wr) begin
            if (reg_idx == REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[FW_W-1:0];
            end else begin
                frame_height_reg <= pwdata[FH_W-1:0];
            end
        end
    end

    always_comb begin
        if (frame_width_reg < FW_W'(MIN_DIM)) begin
            w_eff = FW_W'(MIN_DIM);
        end else if (frame_width_reg > FW_W'(MAX_WIDTH)) begin
            w_eff = FW_W'(MAX_WIDTH);
        end else begin
            w_eff = frame_width_reg;
        end
        if (frame_height_reg < FH_W'(MIN_DIM)) begin
            h_eff = FH_W'(MIN_DIM);
        end else if (frame_height_reg > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Accept-edge control: all position bookkeeping is settled here.
    // ------------------------------------------------------------------
    assign s_ready = !p1_valid_reg || p1_adv;
    assign acc     = s_valid && s_ready;
    assign restart = (s_cmd == CMD_PIXEL) && s_frame_start;

    assign col_c  = restart ? '0 : in_col_reg;
    assign row_c  = restart ? '0 : in_row_reg;
    assign done_c = restart ? 1'b0 : done_reg;
    assign orow_c = restart ? '0 : out_row_reg;

    assign pix_ok   = (s_cmd == CMD_PIXEL) && !done_c && ({1'b0, col_c} < w_eff);
    assign pix_have = (row_c >= ROW_W'(1) && col_c >= COL_W'(1)) ||
                      (row_c >= ROW_W'(2) && col_c == '0);
    assign drain_ok = (s_cmd == CMD_DRAIN) && done_reg && (out_row_reg < h_eff);
    assign res      = (pix_ok && pix_have && (orow_c < h_eff)) || drain_ok;

    // Column of the next result, shared by both word kinds (restart zeroes it).
    assign ocol_c = restart ? '0 : out_col_reg;
    assign fend   = (orow_c == h_eff - FH_W'(1)) && ({1'b0, ocol_c} == w_eff - FW_W'(1));

    assign rd_addr = (s_cmd == CMD_DRAIN) ? out_col_reg : col_c;
    assign rd_en   = acc && (pix_ok || drain_ok);

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        done_next    = done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            done_next    = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (acc) begin
            in_col_next  = col_c;
            in_row_next  = row_c;
            done_next    = done_c;
            out_col_next = ocol_c;
            out_row_next = orow_c;
            if (pix_ok) begin
                if ({1'b0, col_c} + FW_W'(1) >= w_eff) begin
                    in_col_next = '0;
                    if ({1'b0, row_c} + FH_W'(1) >= h_eff) begin
                        done_next = 1'b1;
                    end else begin
                        in_row_next = row_c + ROW_W'(1);
                    end
                end else begin
                    in_col_next = col_c + COL_W'(1);
                end
            end
            if (res) begin
                if ({1'b0, ocol_c} + FW_W'(1) == w_eff) begin
                    out_col_next = '0;
                    out_row_next = orow_c + OROW_W'(1);
                end else begin
                    out_col_next = ocol_c + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            done_reg    <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            done_reg    <= done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers. The data stage writes back at its advance edge; a read
    // issued at that same edge to the same column takes the new values
    // from the forwarding registers instead of the RAM.
    // ------------------------------------------------------------------
    lmt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .aclk    (aclk),
        .wr_en   (p1_adv && p1_reg.wr),
        .wr_addr (p1_reg.addr),
        .wr_data (mid),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (two_q)
    );

    lmt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .aclk    (aclk),
        .wr_en   (p1_adv && p1_reg.wr),
        .wr_addr (p1_reg.addr),
        .wr_data (p1_reg.px),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (above_q)
    );

    assign top = fwd_reg ? fwd_two_reg : two_q;
    assign mid = fwd_reg ? fwd_above_reg : above_q;

    // ------------------------------------------------------------------
    // Data stage: window shift and threshold decision.
    // ------------------------------------------------------------------
    assign p1_adv = p1_valid_reg && (!p1_reg.have || !out_valid_reg || m_ready);

    always_comb begin
        win_new[0] = win_reg[1];
        win_new[1] = win_reg[2];
        win_new[2] = top;
        win_new[3] = win_reg[4];
        win_new[4] = win_reg[5];
        win_new[5] = mid;
        win_new[6] = win_reg[7];
        win_new[7] = win_reg[8];
        win_new[8] = p1_reg.px;
    end

    assign sum = SUM_W'(win_new[0]) + SUM_W'(win_new[1]) + SUM_W'(win_new[2]) +
                 SUM_W'(win_new[3]) + SUM_W'(win_new[4]) + SUM_W'(win_new[5]) +
                 SUM_W'(win_new[6]) + SUM_W'(win_new[7]) + SUM_W'(win_new[8]);
    assign nine_c = SUM_W'({win_reg[5], 3'b000}) + SUM_W'(win_reg[5]);

    // The centre after the shift is the old middle-right pixel, which is
    // also the line-end pixel reported at column zero.
    always_comb begin
        if (p1_reg.drain) begin
            val = p1_reg.sel_above ? mid : top;
        end else if (p1_reg.border) begin
            val = win_reg[5];
        end else if (sum > nine_c) begin
            val = PIX_BLACK;
        end else begin
            val = PIX_WHITE;
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (rd_en) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            if (rd_en) begin
                fwd_reg <= p1_adv && p1_reg.wr && (p1_reg.addr == rd_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            p1_reg.wr        <= pix_ok;
            p1_reg.have      <= res;
            p1_reg.drain     <= drain_ok;
            p1_reg.sel_above <= (orow_c == h_eff - FH_W'(1));
            p1_reg.border    <= (row_c == ROW_W'(1)) || (col_c <= COL_W'(1));
            p1_reg.frame_end <= fend;
            p1_reg.addr      <= rd_addr;
            p1_reg.px        <= s_pixel_in;
            fwd_two_reg      <= mid;
            fwd_above_reg    <= p1_reg.px;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (p1_adv && p1_reg.wr) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_new[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_comb begin
        out_valid_next = out_valid_reg;
        if (p1_adv && p1_reg.have) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_reg.have) begin
            pixel_out_reg <= val;
            frame_end_reg <= p1_reg.frame_end;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = pixel_out_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// ===== rtl/lmt_checker.sv =====
// Port-level checks for the 3x3 local-mean threshold block.
// Depends on lmt_pkg; bound to local_mean_threshold_3x3 at the end of this file.
module lmt_checker
    import lmt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [PIX_W-1:0]  m_pixel_out,
    input logic              m_frame_end,
    input logic              pready
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_frame_end))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset empties the data stage, so the input side is open.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // A word that appears on an empty output was accepted at the input and passed the data stage.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input word");

    a_pready: assert property (@(posedge aclk)
        pready)
        else $error("configuration port not ready");

endmodule

bind local_mean_threshold_3x3 lmt_checker u_lmt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_out (m_pixel_out),
    .m_frame_end (m_frame_end),
    .pready      (pready)
);

// ===== dv/tb_local_mean_threshold_3x3.sv =====
// Self-checking testbench for the streaming 3x3 local-mean threshold block.
// Depends on lmt_pkg and the local_mean_threshold_3x3 top level; the expected
// pixel stream comes from a line-buffer predictor kept inside this file.
`timescale 1ns / 100ps

module tb_local_mean_threshold_3x3;
    import lmt_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PIPE_SETTLE = 8;
    localparam int MAX_PRINTS  = 100;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_WORDS  = 250;

    typedef enum logic [1:0] {
        ROW_OPEN,
        ROW_NONE,
        ROW_GIVES
    } row_kind_t;

    typedef enum logic [1:0] {
        PAT_NOISE,
        PAT_FLAT,
        PAT_NEAR_FLAT,
        PAT_BINARY
    } pix_style_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_BURSTY
    } rdy_mode_t;

    typedef struct {
        lmt_cmd_t         cmd;
        logic [PIX_W-1:0] px;
        logic             fs;
        row_kind_t        kind;
        logic [PIX_W-1:0] want_px;
        logic             want_fe;
    } stim_row_t;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic             fe;
    } pixel_due_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [PIX_W-1:0]  s_pixel_in;
    logic              s_frame_start;
    logic              m_valid;
    logic              m_ready;
    logic [PIX_W-1:0]  m_pixel_out;
    logic              m_frame_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state: line buffers, window, positions and register copies.
    logic [PIX_W-1:0] row_above     [MAX_WIDTH];
    logic [PIX_W-1:0] row_two_above [MAX_WIDTH];
    logic [PIX_W-1:0] win           [9];
    int               in_col;
    int               in_row;
    int               out_pos;
    bit               pix_done;
    logic [FW_W-1:0]  cfg_w;
    logic [FH_W-1:0]  cfg_h;

    pixel_due_t results_due[$];
    bit         last_gave;
    pixel_due_t last_due;

    int          err_count;
    int          words_sent;
    int          results_seen;
    int          frame_ends_seen;
    int          settings_used;
    int          frame_words;
    int          burst_left;
    int unsigned cycles;

    // Directed words. Frame A is 3x3 with a black centre amid bright corners,
    // frame B is flat so its centre sits exactly on the threshold.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_DRAIN, 8'h5A, 1'b1, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 1'b1, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h00, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h00, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h00, 1'b0, ROW_GIVES, 8'hFF, 1'b0},
        '{CMD_PIXEL, 8'h00, 1'b0, ROW_GIVES, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 1'b0, ROW_GIVES, 8'hFF, 1'b0},
        '{CMD_PIXEL, 8'h00, 1'b0, ROW_GIVES, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 1'b0, ROW_GIVES, 8'h00, 1'b0},
        '{CMD_DRAIN, 8'hC3, 1'b0, ROW_GIVES, 8'h00, 1'b0},
        '{CMD_DRAIN, 8'h3C, 1'b0, ROW_GIVES, 8'hFF, 1'b0},
        '{CMD_DRAIN, 8'h00, 1'b1, ROW_GIVES, 8'h00, 1'b0},
        '{CMD_DRAIN, 8'hFF, 1'b0, ROW_GIVES, 8'hFF, 1'b1},
        '{CMD_DRAIN, 8'hA5, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h3C, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b1, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_NONE,  8'h00, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_GIVES, 8'h80, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_GIVES, 8'h80, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_GIVES, 8'h80, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_GIVES, 8'h80, 1'b0},
        '{CMD_PIXEL, 8'h80, 1'b0, ROW_GIVES, 8'hFF, 1'b0}
    };

    local_mean_threshold_3x3 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_frame_end   (m_frame_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_width();
        return clamp_dim(int'(cfg_w), MAX_WIDTH);
    endfunction

    function automatic int eff_height();
        return clamp_dim(int'(cfg_h), MAX_HEIGHT);
    endfunction

    task automatic restart_position();
        in_col   = 0;
        in_row   = 0;
        out_pos  = 0;
        pix_done = 1'b0;
    endtask

    // Works out the result word, if any, that one accepted input word causes.
    task automatic predict_threshold(input lmt_cmd_t cmd, input logic [PIX_W-1:0] px,
                                     input logic fs, output bit got,
                                     output pixel_due_t res);
        int w;
        int h;
        int total;
        int c;
        int r;
        int sum;
        bit have;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] prev_right;

        w = eff_width();
        h = eff_height();
        total = w * h;
        got = 1'b0;
        have = 1'b0;
        res.px = PIX_BLACK;
        res.fe = 1'b0;
        if (cmd == CMD_DRAIN) begin
            // Drains only flush once the frame's last pixel has gone in.
            if (pix_done && out_pos < total) begin
                r = out_pos / w;
                c = out_pos % w;
                res.px = (r == h - 1) ? row_above[c] : row_two_above[c];
                got = 1'b1;
            end
        end else begin
            if (fs) restart_position();
            if (!pix_done && in_col < w) begin
                c = in_col;
                r = in_row;
                top = row_two_above[c];
                mid = row_above[c];
                row_two_above[c] = mid;
                row_above[c] = px;
                prev_right = win[5];
                for (int k = 0; k < 3; k++) begin
                    win[k*3]     = win[k*3 + 1];
                    win[k*3 + 1] = win[k*3 + 2];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = px;
                if (r >= 1 && c >= 1) begin
                    have = 1'b1;
                    if (r - 1 < 1 || c - 1 < 1 || r - 1 >= h - 1 || c - 1 >= w - 1) begin
                        res.px = win[4];
                    end else begin
                        sum = 0;
                        for (int k = 0; k < 9; k++) sum += int'(win[k]);
                        res.px = (sum > 9 * int'(win[4])) ? PIX_BLACK : PIX_WHITE;
                    end
                end else if (r >= 2 && c == 0) begin
                    // Column 0 emits the right-hand border pixel of the line
                    // two above, still held in the middle row of the window.
                    have = 1'b1;
                    res.px = prev_right;
                end
                if (c + 1 >= w) begin
                    in_col = 0;
                    if (r + 1 >= h) pix_done = 1'b1;
                    else in_row = r + 1;
                end else begin
                    in_col = c + 1;
                end
                got = have && (out_pos < total);
            end
        end
        if (got) begin
            res.fe = (out_pos == total - 1);
            out_pos++;
        end
    endtask

    // Register i sits at byte address 4*i. Bits above the field are sometimes
    // set to show that they are ignored.
    task automatic write_reg(input logic idx, input int value);
        logic [DATA_W-1:0] data;

        data = DATA_W'(value);
        if ($urandom_range(0, 3) == 0) begin
            data = data | (DATA_W'($urandom) << ((idx == REG_FRAME_WIDTH) ? FW_W : FH_W));
        end
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_w = data[FW_W-1:0];
        else cfg_h = data[FH_W-1:0];
        restart_position();
        settings_used++;
    endtask

    // Sends one word in bursts of random length, then predicts its result.
    task automatic send_word(input lmt_cmd_t cmd, input logic [PIX_W-1:0] px,
                             input logic fs);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid    = 1'b0;
                s_pixel_in = PIX_W'($urandom);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid       = 1'b1;
        s_cmd         = cmd;
        s_pixel_in    = px;
        s_frame_start = fs;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
        predict_threshold(cmd, px, fs, last_gave, last_due);
        if (last_gave) results_due.push_back(last_due);
    endtask

    // Lowers valid and waits until every predicted word is back and the
    // pipeline has had time to finish words that give no result.
    task automatic wait_idle();
        int waited;

        waited = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_due.size() != 0 && waited < IDLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (results_due.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived", results_due.size()));
            results_due.delete();
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic set_frame_size(input int wv, input int hv);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input pix_style_t style,
                                                    input logic [PIX_W-1:0] base);
        case (style)
            PAT_FLAT:      return base;
            PAT_NEAR_FLAT: return base ^ PIX_W'($urandom_range(0, 3));
            PAT_BINARY:    return ($urandom_range(0, 1) == 1) ? PIX_WHITE : PIX_BLACK;
            default:       return PIX_W'($urandom);
        endcase
    endfunction

    // One frame at the current size. A frame cut short stops after pix_limit
    // pixels and is dropped by the next frame start or register write.
    task automatic send_frame(input int pix_limit);
        int w;
        int total;
        int npix;
        pix_style_t style;
        logic [PIX_W-1:0] base;

        w = eff_width();
        total = w * eff_height();
        npix = (pix_limit < total) ? pix_limit : total;
        style = pix_style_t'($urandom_range(0, 3));
        base = PIX_W'($urandom);
        for (int n = 0; n < npix; n++) begin
            if ($urandom_range(0, 59) == 0) begin
                send_word(CMD_DRAIN, PIX_W'($urandom), 1'($urandom_range(0, 1)));
            end
            send_word(CMD_PIXEL, make_pixel(style, base), n == 0);
        end
        frame_words += npix;
        if (npix == total) begin
            for (int n = 0; n <= w; n++) begin
                send_word(CMD_DRAIN, PIX_W'($urandom), $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 19) == 0) send_word(CMD_PIXEL, PIX_W'($urandom), 1'b0);
            end
            frame_words += w + 1;
            if ($urandom_range(0, 3) == 0) send_word(CMD_DRAIN, PIX_W'($urandom), 1'b0);
        end
    endtask

    // Receiver: ready follows one of four patterns, picked anew at random.
    initial begin
        rdy_mode_t mode;
        int left;
        int period;
        int hold;
        int tick;

        m_ready = 1'b0;
        left = 0;
        hold = 0;
        tick = 0;
        period = 2;
        mode = RDY_ALWAYS;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = rdy_mode_t'($urandom_range(0, 3));
                left = $urandom_range(50, 400);
                period = $urandom_range(2, 7);
            end
            left--;
            tick++;
            case (mode)
                RDY_ALWAYS:   m_ready = 1'b1;
                RDY_RANDOM:   m_ready = ($urandom_range(0, 99) < 70);
                RDY_PERIODIC: m_ready = (tick % period) != 0;
                default: begin
                    if (hold > 0) begin
                        hold--;
                        m_ready = 1'b0;
                    end else if ($urandom_range(0, 29) == 0) begin
                        hold = $urandom_range(1, 20);
                        m_ready = 1'b0;
                    end else begin
                        m_ready = 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        pixel_due_t want;

        if (aresetn) begin
            if ($isunknown(m_valid)) begin
                report_mismatch("m_valid is unknown");
            end else if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result word %02h with none expected",
                                              m_pixel_out));
                end else begin
                    want = results_due.pop_front();
                    if (m_pixel_out !== want.px) begin
                        report_mismatch($sformatf("result %0d: m_pixel_out %02h, expected %02h",
                                                  results_seen, m_pixel_out, want.px));
                    end
                    if (m_frame_end !== want.fe) begin
                        report_mismatch($sformatf("result %0d: m_frame_end %b, expected %b",
                                                  results_seen, m_frame_end, want.fe));
                    end
                    if (want.fe) frame_ends_seen++;
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("local_mean_threshold_3x3 regression: fail");
            $finish;
        end
    end

    initial begin
        int wv;
        int hv;
        int total;
        int pick;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_PIXEL;
        s_pixel_in    = '0;
        s_frame_start = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            row_above[k]     = '0;
            row_two_above[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        restart_position();
        cfg_w = FW_W'(FRAME_WIDTH_RESET);
        cfg_h = FH_W'(FRAME_HEIGHT_RESET);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Part of a frame at the reset size, before any register write.
        send_frame(330);

        // Out-of-range low values give the smallest 3x3 frame.
        set_frame_size(2, 0);
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_word(dir_rows[i].cmd, dir_rows[i].px, dir_rows[i].fs);
            case (dir_rows[i].kind)
                ROW_NONE: begin
                    if (last_gave) report_mismatch($sformatf("directed word %0d gave a result", i));
                end
                ROW_GIVES: begin
                    if (!last_gave || last_due.px !== dir_rows[i].want_px ||
                        last_due.fe !== dir_rows[i].want_fe) begin
                        report_mismatch($sformatf("directed word %0d: predicted result is off", i));
                    end
                end
                default: ;
            endcase
        end

        // Largest sizes, as partial frames to keep the run short.
        set_frame_size(1023, 3);
        send_frame(520);
        set_frame_size(0, 2047);
        send_frame(60);
        set_frame_size(512, 1024);
        send_frame(20);

        frame_words = 0;
        while (frame_words < RAND_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) wv = $urandom_range(0, 2);
            else if (pick < 3) wv = $urandom_range(11, 40);
            else wv = $urandom_range(3, 10);
            pick = $urandom_range(0, 9);
            if (pick == 0) hv = $urandom_range(0, 2);
            else if (pick == 1) hv = $urandom_range(9, 16);
            else hv = $urandom_range(3, 8);
            wait_idle();
            pick = $urandom_range(0, 5);
            if (pick != 1) write_reg(REG_FRAME_WIDTH, wv);
            if (pick != 0) write_reg(REG_FRAME_HEIGHT, hv);
            repeat ($urandom_range(1, 3)) begin
                total = eff_width() * eff_height();
                if ($urandom_range(0, 7) == 0) send_frame($urandom_range(1, total - 1));
                else send_frame(total);
            end
        end

        wait_idle();
        $display("Covered %0d input words and %0d result words over %0d register writes,",
                 words_sent, results_seen, settings_used);
        $display("with %0d frames flushed to their last result and partial frames at the largest sizes.",
                 frame_ends_seen);
        if (err_count == 0) begin
            $display("local_mean_threshold_3x3 regression: pass");
        end else begin
            $display("local_mean_threshold_3x3 regression: fail");
        end
        $finish;
    end

endmodule
